// File: rtl/organized_depth_grid_triangulator_unit_defines.svh
// Assertion macros used by the triangulator top level.
`ifndef ORGANIZED_DEPTH_GRID_TRIANGULATOR_UNIT_DEFINES_SVH
`define ORGANIZED_DEPTH_GRID_TRIANGULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODGT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("odgt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ODGT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("odgt: next-cycle check failed");

`endif

// File: rtl/odgt_pkg.sv
// Types, constants and helper functions of the depth grid triangulator.
`timescale 1ns / 1ps

package odgt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W = $clog2(2 * MAX_WIDTH);
    localparam int RAM_DEPTH = 2 * MAX_WIDTH;

    localparam int DEPTH_W = 16;
    localparam int VNUM_W  = 20;
    localparam int POS_W   = 10;
    localparam int IW_W    = 11;
    localparam int LIM_W   = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    // input tuser bit positions
    localparam int TU_VALID = 0;
    localparam int TU_FRAME = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP_LIMIT = 1'b1;

    localparam logic [IW_W-1:0]  IMAGE_WIDTH_RESET = 11'd640;
    localparam logic [LIM_W-1:0] DEPTH_LIMIT_RESET = 16'd256;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               valid;
        logic               vset;
        logic [VNUM_W-1:0]  vnum;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               valid;
        logic               frame_start;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               par;
    } t_pixel;

    // Emission slots of one quad, in output order.
    typedef enum logic [2:0] {
        SL_UP_T1   = 3'd0,
        SL_DIAG_T1 = 3'd1,
        SL_LEFT_T1 = 3'd2,
        SL_TRI1    = 3'd3,
        SL_UP_T2   = 3'd4,
        SL_LEFT_T2 = 3'd5,
        SL_CUR_T2  = 3'd6,
        SL_TRI2    = 3'd7
    } t_slot;

    localparam int NUM_SLOTS = 8;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SETUP,
        ENG_EMIT
    } t_eng_state;

    function automatic logic close_enough(input logic [DEPTH_W-1:0] a,
                                          input logic [DEPTH_W-1:0] b,
                                          input logic [LIM_W-1:0]   lim);
        logic [DEPTH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d < lim;
    endfunction

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (int'(r) < MAX_HEIGHT - 1) ? r + ROW_W'(1) : r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic par,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = par ? ADDR_W'(MAX_WIDTH) : '0;
        return base + ADDR_W'(col);
    endfunction

    function automatic t_slot first_slot(input logic [NUM_SLOTS-1:0] m);
        t_slot s;
        s = SL_UP_T1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) s = t_slot'(3'(i));
        end
        return s;
    endfunction

endpackage

// File: rtl/odgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module odgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/organized_depth_grid_triangulator_unit.sv
// Top level of the organized depth grid triangulator.
//
// Usage:
//   Slave stream: one depth pixel per word in raster order. tdata carries the
//   Q8.8 depth; tuser carries the valid flag and the frame start flag. A word
//   with frame start resets row, column, parity and the vertex counter.
//   Master stream: one result per word. tuser gives the kind (vertex event or
//   triangle), tdata the vertex numbers and the grid position, tlast marks the
//   final result of a pixel. Pixels that close no kept triangle send nothing.
//   Configuration: plain write port, image width (index 0) and the depth step
//   limit (index 1); write only while the block is idle.
// Timing:
//   A pixel gets an engine setup cycle, then sends its results (0..6). Setup
//   reads the upper row entry from the row buffer RAM and writes the new
//   pixel; each further cycle with a free output sends one result and writes
//   back at most one updated entry through the single write port. A pixel
//   goes from the input holding register via setup and emit to the output
//   register; the holding register takes the next pixel while the engine is busy.
// Reset: counters and config return to defaults; the row buffer RAM is not
//   cleared and holds whatever was written before.
// Stall: a stalled master side holds the output word and freezes the engine;
//   the input side then fills its holding register and drops tready.
`timescale 1ns / 1ps
`include "organized_depth_grid_triangulator_unit_defines.svh"

module organized_depth_grid_triangulator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [odgt_pkg::S_TDATA_W-1:0]   i_s_tdata,   // [15:0] depth
    input  logic [odgt_pkg::S_TUSER_W-1:0]   i_s_tuser,   // [0] valid_req, [1] frame_start
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [19:0] vertex_a, [39:20] vertex_b, [59:40] vertex_c,
    // [69:60] source_row, [79:70] source_col
    output logic [odgt_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [odgt_pkg::M_TUSER_W-1:0]   o_m_tuser,   // [0] kind
    output logic                             o_m_tlast,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [odgt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [odgt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    import odgt_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [IW_W-1:0]  r_image_width;
    logic [LIM_W-1:0] r_depth_limit;
    logic [CNT_W-1:0] w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RESET;
            r_depth_limit <= DEPTH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:      r_image_width <= i_cfg_wdata[IW_W-1:0];
                CFG_DEPTH_STEP_LIMIT: r_depth_limit <= i_cfg_wdata[LIM_W-1:0];
                default:              r_image_width <= r_image_width;
            endcase
        end
    end

    // Clamp the width into 2..MAX_WIDTH.
    always_comb begin
        if (r_image_width < IW_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_image_width);
        end
    end

    // ---------------------------------------------------------------
    // Front end: grid position counters and input holding register
    // ---------------------------------------------------------------
    logic [COL_W-1:0] r_col, n_col, f_col0, f_col;
    logic [ROW_W-1:0] r_row, n_row, f_row0, f_row;
    logic             r_par, n_par, f_par0, f_par;
    logic [CNT_W-1:0] col_inc;
    logic             s_accept;
    logic             q_load;
    logic             r_q_valid;
    t_pixel           r_q;
    t_pixel           f_pix;

    // Position of the arriving pixel and the counters after it.
    always_comb begin
        f_col0 = i_s_tuser[TU_FRAME] ? '0 : r_col;
        f_row0 = i_s_tuser[TU_FRAME] ? '0 : r_row;
        f_par0 = i_s_tuser[TU_FRAME] ? 1'b0 : r_par;
        f_col  = f_col0;
        f_row  = f_row0;
        f_par  = f_par0;
        // width shrunk mid row: start the next row first
        if (CNT_W'(f_col0) >= w_eff) begin
            f_col = '0;
            f_row = row_inc(f_row0);
            f_par = ~f_par0;
        end
        col_inc = CNT_W'(f_col) + CNT_W'(1);
        n_col   = COL_W'(col_inc);
        n_row   = f_row;
        n_par   = f_par;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = row_inc(f_row);
            n_par = ~f_par;
        end
        f_pix = '{depth:       i_s_tdata[DEPTH_W-1:0],
                  valid:       i_s_tuser[TU_VALID],
                  frame_start: i_s_tuser[TU_FRAME],
                  col:         f_col,
                  row:         f_row,
                  par:         f_par};
    end

    assign o_s_tready = !r_q_valid || q_load;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_par     <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_par     <= n_par;
                r_q_valid <= 1'b1;
            end else if (q_load) begin
                r_q_valid <= 1'b0;
            end
        end
    end

    // hold the pixel word until the engine takes it
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_q <= f_pix;
        end
    end

    // ---------------------------------------------------------------
    // Row buffer RAM: two rows of entries, selected by parity
    // ---------------------------------------------------------------
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign ram_raddr = slot_addr(~r_q.par, r_q.col);

    odgt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (q_load),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Engine: setup cycle, then while the output is free one result per cycle
    // ---------------------------------------------------------------
    t_eng_state           r_state, n_state;
    t_pixel               r_p;
    // quad corners: c1 up, c2 diagonal, c3 left, c0 current
    t_entry               r_c0, r_c1, r_c2, r_c3;
    logic [NUM_SLOTS-1:0] r_mask, mask_c, mask_rem;
    logic [VNUM_W-1:0]    r_nv;
    logic                 r_fwd_hit;
    t_entry               r_fwd_data;

    t_entry               e0, e1;
    logic                 quad, k123, k130;
    logic [ADDR_W-1:0]    a_up, a_diag, a_left, a_cur;
    t_slot                slot;
    logic                 slot_last;
    logic                 out_free;
    logic                 eng_done;
    logic                 emit;

    // result formatting
    t_entry               sel;
    t_entry               upd;
    logic [ADDR_W-1:0]    sel_addr;
    logic                 is_vtx;
    logic [POS_W-1:0]     pos_row, pos_col;
    logic [VNUM_W-1:0]    t_a, t_b, t_c;

    logic                 r_ov;
    logic                 r_o_kind;
    logic [VNUM_W-1:0]    r_o_va, r_o_vb, r_o_vc;
    logic [POS_W-1:0]     r_o_row, r_o_col;
    logic                 r_o_last;

    assign out_free = !r_ov || i_m_tready;

    assign a_up   = slot_addr(~r_p.par, r_p.col);
    assign a_diag = slot_addr(~r_p.par, r_p.col - COL_W'(1));
    assign a_left = slot_addr(r_p.par, r_p.col - COL_W'(1));
    assign a_cur  = slot_addr(r_p.par, r_p.col);

    // Quad tests: upper entry comes from the RAM (or the write forwarded
    // in the read cycle), left corners from the previous pixel's registers.
    always_comb begin
        e1   = r_fwd_hit ? r_fwd_data : t_entry'(ram_rdata);
        e0   = '{depth: r_p.depth, valid: r_p.valid, vset: 1'b0, vnum: '0};
        quad = (r_p.row != '0) && (r_p.col != '0);
        k123 = quad && e1.valid && r_c1.valid && r_c0.valid
               && close_enough(e1.depth, r_c1.depth, r_depth_limit)
               && close_enough(e1.depth, r_c0.depth, r_depth_limit)
               && close_enough(r_c1.depth, r_c0.depth, r_depth_limit);
        k130 = quad && e1.valid && r_c0.valid && e0.valid
               && close_enough(e1.depth, r_c0.depth, r_depth_limit)
               && close_enough(e1.depth, e0.depth, r_depth_limit)
               && close_enough(r_c0.depth, e0.depth, r_depth_limit);
        mask_c             = '0;
        mask_c[SL_UP_T1]   = k123 && !e1.vset;
        mask_c[SL_DIAG_T1] = k123 && !r_c1.vset;
        mask_c[SL_LEFT_T1] = k123 && !r_c0.vset;
        mask_c[SL_TRI1]    = k123;
        // corners numbered by the first triangle are already set
        mask_c[SL_UP_T2]   = k130 && !e1.vset && !k123;
        mask_c[SL_LEFT_T2] = k130 && !r_c0.vset && !k123;
        mask_c[SL_CUR_T2]  = k130;
        mask_c[SL_TRI2]    = k130;
    end

    assign slot      = first_slot(r_mask);
    assign mask_rem  = r_mask & (r_mask - NUM_SLOTS'(1));
    assign slot_last = (mask_rem == '0);

    // Select the corner or triangle that the current slot sends.
    always_comb begin
        sel      = r_c0;
        sel_addr = a_cur;
        is_vtx   = 1'b1;
        pos_row  = POS_W'(r_p.row);
        pos_col  = POS_W'(r_p.col);
        t_a      = r_c1.vnum;
        t_b      = r_c2.vnum;
        t_c      = r_c3.vnum;
        unique case (slot)
            SL_UP_T1, SL_UP_T2: begin
                sel      = r_c1;
                sel_addr = a_up;
                pos_row  = POS_W'(r_p.row - ROW_W'(1));
            end
            SL_DIAG_T1: begin
                sel      = r_c2;
                sel_addr = a_diag;
                pos_row  = POS_W'(r_p.row - ROW_W'(1));
                pos_col  = POS_W'(r_p.col - COL_W'(1));
            end
            SL_LEFT_T1, SL_LEFT_T2: begin
                sel      = r_c3;
                sel_addr = a_left;
                pos_col  = POS_W'(r_p.col - COL_W'(1));
            end
            SL_CUR_T2: begin
                sel      = r_c0;
                sel_addr = a_cur;
            end
            SL_TRI1: begin
                is_vtx = 1'b0;
            end
            SL_TRI2: begin
                is_vtx = 1'b0;
                t_b    = r_c3.vnum;
                t_c    = r_c0.vnum;
            end
        endcase
        upd      = sel;
        upd.vset = 1'b1;
        upd.vnum = r_nv;
    end

    // Next state of the engine.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE: begin
                if (r_q_valid) n_state = ENG_SETUP;
            end
            ENG_SETUP: begin
                if (mask_c != '0) begin
                    n_state = ENG_EMIT;
                end else if (!r_q_valid) begin
                    n_state = ENG_IDLE;
                end
            end
            ENG_EMIT: begin
                if (out_free && slot_last) begin
                    n_state = r_q_valid ? ENG_SETUP : ENG_IDLE;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    // Engine outputs: completion, emission and the RAM write port.
    always_comb begin
        eng_done  = 1'b0;
        emit      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = a_cur;
        ram_wdata = e0;
        unique case (r_state)
            ENG_IDLE: begin
                eng_done = 1'b1;
            end
            ENG_SETUP: begin
                // store the new pixel with no vertex number yet
                ram_we   = 1'b1;
                eng_done = (mask_c == '0);
            end
            ENG_EMIT: begin
                emit      = out_free;
                eng_done  = out_free && slot_last;
                ram_we    = out_free && is_vtx;
                ram_waddr = sel_addr;
                ram_wdata = upd;
            end
            default: eng_done = 1'b1;
        endcase
    end

    assign q_load = r_q_valid && eng_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ENG_IDLE;
            r_mask    <= '0;
            r_nv      <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_state   <= n_state;
            // forward a write that lands on the address being read
            r_fwd_hit <= q_load && ram_we && (ram_waddr == ram_raddr);
            if (r_state == ENG_SETUP) begin
                r_mask <= mask_c;
                if (r_p.frame_start) r_nv <= '0;
            end else if (emit) begin
                r_mask <= mask_rem;
                if (is_vtx) r_nv <= r_nv + VNUM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        if (q_load) begin
            r_p <= r_q;
        end
        if (r_state == ENG_SETUP) begin
            // shift the quad one column right
            r_c2 <= r_c1;
            r_c3 <= r_c0;
            r_c1 <= e1;
            r_c0 <= e0;
        end else if (emit && is_vtx) begin
            unique case (slot)
                SL_UP_T1, SL_UP_T2:     r_c1 <= upd;
                SL_DIAG_T1:             r_c2 <= upd;
                SL_LEFT_T1, SL_LEFT_T2: r_c3 <= upd;
                SL_CUR_T2:              r_c0 <= upd;
                SL_TRI1, SL_TRI2:       r_c0 <= r_c0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind <= is_vtx ? KIND_VERTEX : KIND_TRIANGLE;
            r_o_va   <= is_vtx ? r_nv : t_a;
            r_o_vb   <= is_vtx ? '0 : t_b;
            r_o_vc   <= is_vtx ? '0 : t_c;
            r_o_row  <= is_vtx ? pos_row : '0;
            r_o_col  <= is_vtx ? pos_col : '0;
            r_o_last <= slot_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_o_col, r_o_row, r_o_vc, r_o_vb, r_o_va};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // the emit state always has a slot left to send
    `ODGT_ASSERT_NOW(a_emit_has_slot, i_clk, i_rst_n, r_state == ENG_EMIT, r_mask != '0)
    // every vertex event is followed by its triangle, so a pixel ends on one
    `ODGT_ASSERT_NOW(a_last_is_triangle, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser == KIND_TRIANGLE)
    // a pixel taken by the engine gets its setup cycle next
    `ODGT_ASSERT_NEXT(a_load_to_setup, i_clk, i_rst_n, q_load, r_state == ENG_SETUP)

endmodule
